[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the calendar converter RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, held off while reset is asserted.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked check that also applies during reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/core/ecc_pkg.sv]
// ----------------------------------------------------------------------------
// ecc_pkg
// Types, constants and the four-year day table of the calendar converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ecc_pkg;

    typedef enum logic [1:0] {
        OP_TO_SECONDS  = 2'd0,
        OP_TO_CALENDAR = 2'd1,
        OP_DAY_SECONDS = 2'd2,
        OP_NONE        = 2'd3
    } ecc_op_t;

    localparam int unsigned DAYS_PER_CYCLE = 365 * 4 + 1;
    localparam int unsigned SECS_PER_HOUR  = 3600;
    localparam int unsigned SECS_PER_MIN   = 60;
    // 86400 = 675 << 7
    localparam int unsigned DAY_UNITS      = 86400 / 128;

    // floor(x / d) == (x * RECIP) >> SHIFT over the operand range used
    localparam logic [25:0] DAY_RECIP    = 26'd50903317;  // /675, x < 2^25
    localparam int unsigned DAY_SHIFT    = 35;
    localparam logic [13:0] HOUR_RECIP   = 14'd9321;      // /225, x < 2^13
    localparam int unsigned HOUR_SHIFT   = 21;
    localparam logic [10:0] MIN_RECIP    = 11'd1093;      // /15,  x < 2^10
    localparam int unsigned MIN_SHIFT    = 14;
    localparam logic [16:0] CYCLE_RECIP  = 17'd91868;     // /1461, x < 2^16
    localparam int unsigned CYCLE_SHIFT  = 27;

    // Day number at the first of each month over a four-year cycle
    localparam logic [10:0] CYCLE_DAYS [4][12] = '{
        '{11'd0,    11'd31,   11'd60,   11'd91,   11'd121,  11'd152,
          11'd182,  11'd213,  11'd244,  11'd274,  11'd305,  11'd335},
        '{11'd366,  11'd397,  11'd425,  11'd456,  11'd486,  11'd517,
          11'd547,  11'd578,  11'd609,  11'd639,  11'd670,  11'd700},
        '{11'd731,  11'd762,  11'd790,  11'd821,  11'd851,  11'd882,
          11'd912,  11'd943,  11'd974,  11'd1004, 11'd1035, 11'd1065},
        '{11'd1096, 11'd1127, 11'd1155, 11'd1186, 11'd1216, 11'd1247,
          11'd1277, 11'd1308, 11'd1339, 11'd1369, 11'd1400, 11'd1430}
    };

    typedef struct packed {
        ecc_op_t     op;
        logic [31:0] seconds;
        logic [6:0]  year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } ecc_in_t;

    typedef struct packed {
        ecc_op_t     op;
        logic        err;
        logic [24:0] dhi;     // day number * 675
        logic [16:0] hms;     // hour/minute/second of a date, in seconds
        logic [15:0] days;    // whole days of seconds_in
        logic [16:0] sod;     // seconds of day of seconds_in
    } ecc_st2_t;

    typedef struct packed {
        ecc_op_t     op;
        logic        err;
        logic [31:0] word;    // final seconds_out
        logic [4:0]  hour;
        logic [5:0]  cyc;     // four-year cycles
        logic [11:0] r2;      // seconds within the hour
        logic [10:0] drem;    // day within the cycle
    } ecc_st4_t;

    typedef struct packed {
        logic [31:0] seconds;
        logic [7:0]  year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic        range_error;
    } ecc_out_t;

endpackage

`default_nettype wire

[rtl/core/ecc_day_split.sv]
// ----------------------------------------------------------------------------
// ecc_day_split
// Stages 1-2: splits seconds into days and seconds of day; turns a date
// into a day number and a time of day.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ecc_day_split (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  ecc_pkg::ecc_in_t   in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output ecc_pkg::ecc_st2_t  out_data
);
    import ecc_pkg::*;

    typedef struct packed {
        ecc_op_t     op;
        logic        err;
        logic [15:0] dnum;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [50:0] prod;
        logic [24:0] quot_src;
        logic [6:0]  low_bits;
    } st1_t;

    logic        v1_reg, v1_next;
    logic        v2_reg, v2_next;
    st1_t        st1_reg, st1_next;
    ecc_st2_t    st2_reg, st2_next;
    logic        adv1, adv2;
    logic        month_ok, bad;
    logic [3:0]  midx;
    logic [10:0] tbl;
    logic [15:0] days;
    logic [24:0] day_part;
    logic [24:0] rem_part;

    assign adv2     = !v2_reg || out_ready;
    assign adv1     = !v1_reg || adv2;
    assign in_ready = adv1;

    // Stage 1
    always_comb
    begin
        month_ok = (in_data.month != 4'd0) && (in_data.month <= 4'd12);
        bad = (in_data.year > 7'd99) || !month_ok || (in_data.day == 5'd0) ||
              (in_data.hour > 5'd23) || (in_data.minute > 6'd59) ||
              (in_data.second > 6'd59);
        midx = month_ok ? (in_data.month - 4'd1) : 4'd0;
        tbl  = CYCLE_DAYS[in_data.year[1:0]][midx];

        st1_next.op     = in_data.op;
        st1_next.err    = (in_data.op == OP_TO_SECONDS) && bad;
        st1_next.dnum   = 16'({11'd0, in_data.year[6:2]} * 16'(DAYS_PER_CYCLE)) +
                          {5'd0, tbl} + {11'd0, in_data.day} - 16'd1;
        st1_next.hour   = in_data.hour;
        st1_next.minute = in_data.minute;
        st1_next.second = in_data.second;
        st1_next.prod   = {26'd0, in_data.seconds[31:7]} * {25'd0, DAY_RECIP};
        st1_next.quot_src = in_data.seconds[31:7];
        st1_next.low_bits = in_data.seconds[6:0];
    end

    // Stage 2
    always_comb
    begin
        days     = st1_reg.prod[DAY_SHIFT +: 16];
        day_part = {9'd0, days} * 25'(DAY_UNITS);
        rem_part = st1_reg.quot_src - day_part;

        st2_next.op   = st1_reg.op;
        st2_next.err  = st1_reg.err;
        st2_next.dhi  = {9'd0, st1_reg.dnum} * 25'(DAY_UNITS);
        st2_next.hms  = 17'({12'd0, st1_reg.hour} * 17'(SECS_PER_HOUR)) +
                        17'({11'd0, st1_reg.minute} * 17'(SECS_PER_MIN)) +
                        {11'd0, st1_reg.second};
        st2_next.days = days;
        st2_next.sod  = {rem_part[9:0], st1_reg.low_bits};
    end

    always_comb
    begin
        v1_next = adv1 ? in_valid : v1_reg;
        v2_next = adv2 ? v1_reg : v2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1 && in_valid)
        begin
            st1_reg <= st1_next;
        end
        if (adv2 && v1_reg)
        begin
            st2_reg <= st2_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_data  = st2_reg;

    `ASSERT_CLK(a_sod_in_day,
        v2_reg && (st2_reg.op == OP_TO_CALENDAR || st2_reg.op == OP_DAY_SECONDS)
        |-> st2_reg.sod < 17'd86400,
        "seconds of day out of range")

endmodule

`default_nettype wire

[rtl/core/ecc_time_split.sv]
// ----------------------------------------------------------------------------
// ecc_time_split
// Stages 3-4: assembles seconds of a date; splits off hours and four-year
// cycles.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ecc_time_split (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  ecc_pkg::ecc_st2_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output ecc_pkg::ecc_st4_t  out_data
);
    import ecc_pkg::*;

    typedef struct packed {
        ecc_op_t     op;
        logic        err;
        logic [31:0] word;
        logic [15:0] days;
        logic [16:0] sod;
        logic [4:0]  hour;
        logic [5:0]  cyc;
    } st3_t;

    logic        v3_reg, v3_next;
    logic        v4_reg, v4_next;
    st3_t        st3_reg, st3_next;
    ecc_st4_t    st4_reg, st4_next;
    logic        adv3, adv4;
    logic [31:0] total;
    logic [26:0] hour_prod;
    logic [32:0] cyc_prod;

    assign adv4     = !v4_reg || out_ready;
    assign adv3     = !v3_reg || adv4;
    assign in_ready = adv3;

    // Stage 3
    always_comb
    begin
        total     = {in_data.dhi, 7'd0} + {15'd0, in_data.hms};
        hour_prod = {14'd0, in_data.sod[16:4]} * {13'd0, HOUR_RECIP};
        cyc_prod  = {17'd0, in_data.days} * {16'd0, CYCLE_RECIP};

        st3_next.op   = in_data.op;
        st3_next.err  = in_data.err;
        st3_next.days = in_data.days;
        st3_next.sod  = in_data.sod;
        st3_next.hour = hour_prod[HOUR_SHIFT +: 5];
        st3_next.cyc  = cyc_prod[CYCLE_SHIFT +: 6];
        case (in_data.op)
            OP_TO_SECONDS:  st3_next.word = in_data.err ? 32'd0 : total;
            OP_DAY_SECONDS: st3_next.word = {15'd0, in_data.sod};
            default:        st3_next.word = 32'd0;
        endcase
    end

    // Stage 4
    always_comb
    begin
        st4_next.op   = st3_reg.op;
        st4_next.err  = st3_reg.err;
        st4_next.word = st3_reg.word;
        st4_next.hour = st3_reg.hour;
        st4_next.cyc  = st3_reg.cyc;
        st4_next.r2   = 12'(st3_reg.sod -
                            17'({12'd0, st3_reg.hour} * 17'(SECS_PER_HOUR)));
        st4_next.drem = 11'(st3_reg.days -
                            16'({10'd0, st3_reg.cyc} * 16'(DAYS_PER_CYCLE)));
    end

    always_comb
    begin
        v3_next = adv3 ? in_valid : v3_reg;
        v4_next = adv4 ? v3_reg : v4_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v3_reg <= v3_next;
            v4_reg <= v4_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv3 && in_valid)
        begin
            st3_reg <= st3_next;
        end
        if (adv4 && v3_reg)
        begin
            st4_reg <= st4_next;
        end
    end

    assign out_valid = v4_reg;
    assign out_data  = st4_reg;

    `ASSERT_CLK(a_split_bounds,
        v4_reg && st4_reg.op == OP_TO_CALENDAR
        |-> st4_reg.r2 < 12'd3600 && st4_reg.drem < 11'd1461 && st4_reg.hour < 5'd24,
        "hour or cycle split out of range")

    `ASSERT_ALWAYS(a_reset_empty,
        !rst_n |=> !v3_reg && !v4_reg,
        "stage valid set after reset")

endmodule

`default_nettype wire

[rtl/core/ecc_field_out.sv]
// ----------------------------------------------------------------------------
// ecc_field_out
// Stages 5-6: minutes, seconds, year, month and day; output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ecc_field_out (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  ecc_pkg::ecc_st4_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output ecc_pkg::ecc_out_t  out_data
);
    import ecc_pkg::*;

    typedef struct packed {
        ecc_op_t     op;
        logic        err;
        logic [31:0] word;
        logic [4:0]  hour;
        logic [5:0]  cyc;
        logic [11:0] r2;
        logic [10:0] drem;
        logic [5:0]  minute;
        logic [1:0]  yr;
        logic [3:0]  mo;
    } st5_t;

    logic        v5_reg, v5_next;
    logic        v6_reg, v6_next;
    st5_t        st5_reg, st5_next;
    ecc_out_t    st6_reg, st6_next;
    logic        adv5, adv6;
    logic [20:0] min_prod;
    logic [1:0]  yr;
    logic [3:0]  mo;

    assign adv6     = !v6_reg || out_ready;
    assign adv5     = !v5_reg || adv6;
    assign in_ready = adv5;

    // Stage 5: minute and year/month search in the cycle table
    always_comb
    begin
        min_prod = {11'd0, in_data.r2[11:2]} * {10'd0, MIN_RECIP};

        if (in_data.drem >= CYCLE_DAYS[3][0])
            yr = 2'd3;
        else if (in_data.drem >= CYCLE_DAYS[2][0])
            yr = 2'd2;
        else if (in_data.drem >= CYCLE_DAYS[1][0])
            yr = 2'd1;
        else
            yr = 2'd0;

        mo = 4'd0;
        for (int m = 1; m < 12; m++)
        begin
            if (in_data.drem >= CYCLE_DAYS[yr][m])
                mo = 4'(m);
        end

        st5_next.op     = in_data.op;
        st5_next.err    = in_data.err;
        st5_next.word   = in_data.word;
        st5_next.hour   = in_data.hour;
        st5_next.cyc    = in_data.cyc;
        st5_next.r2     = in_data.r2;
        st5_next.drem   = in_data.drem;
        st5_next.minute = min_prod[MIN_SHIFT +: 6];
        st5_next.yr     = yr;
        st5_next.mo     = mo;
    end

    // Stage 6: final fields, zero where the operation does not produce them
    always_comb
    begin
        st6_next.seconds     = st5_reg.word;
        st6_next.range_error = st5_reg.err;
        if (st5_reg.op == OP_TO_CALENDAR)
        begin
            st6_next.year   = {st5_reg.cyc, st5_reg.yr};
            st6_next.month  = st5_reg.mo + 4'd1;
            st6_next.day    = 5'(st5_reg.drem - CYCLE_DAYS[st5_reg.yr][st5_reg.mo] + 11'd1);
            st6_next.hour   = st5_reg.hour;
            st6_next.minute = st5_reg.minute;
            st6_next.second = 6'(st5_reg.r2 -
                                 12'({6'd0, st5_reg.minute} * 12'(SECS_PER_MIN)));
        end
        else
        begin
            st6_next.year   = 8'd0;
            st6_next.month  = 4'd0;
            st6_next.day    = 5'd0;
            st6_next.hour   = 5'd0;
            st6_next.minute = 6'd0;
            st6_next.second = 6'd0;
        end
    end

    always_comb
    begin
        v5_next = adv5 ? in_valid : v5_reg;
        v6_next = adv6 ? v5_reg : v6_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else
        begin
            v5_reg <= v5_next;
            v6_reg <= v6_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv5 && in_valid)
        begin
            st5_reg <= st5_next;
        end
        if (adv6 && v5_reg)
        begin
            st6_reg <= st6_next;
        end
    end

    assign out_valid = v6_reg;
    assign out_data  = st6_reg;

    `ASSERT_CLK(a_error_zero,
        v6_reg && st6_reg.range_error |-> st6_reg.seconds == 32'd0 && st6_reg.month == 4'd0,
        "range error with nonzero result")

    `ASSERT_CLK(a_calendar_range,
        v6_reg && st6_reg.month != 4'd0
        |-> st6_reg.month <= 4'd12 && st6_reg.day != 5'd0 && st6_reg.minute < 6'd60 &&
            st6_reg.second < 6'd60,
        "calendar field out of range")

endmodule

`default_nettype wire

[rtl/core/epoch_calendar_converter.sv]
// ----------------------------------------------------------------------------
// epoch_calendar_converter
// Seconds since 2000-01-01 to and from calendar fields, six-stage pipeline.
// ----------------------------------------------------------------------------
// Channel  Dir  tdata                                  tuser
// s_axis   in   secs, year, month, day, hr, min, sec   operation
// m_axis   out  secs, year, month, day, hr, min, sec   range_error
//
// One transaction per cycle while m_axis is not stalled, through the six register
// stages (one constant-reciprocal multiply level in each pair of stages).
// rst_n clears all stage valid bits; data registers are not reset.
// A stage loads when it is empty or the stage ahead moves on, so a stall
// at m_axis backs up stage by stage and bubbles are squeezed out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module epoch_calendar_converter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // seconds_in[31:0], year_in[38:32], month_in[42:39], day_in[47:43],
    // hour_in[52:48], minute_in[58:53], second_in[64:59], zero fill
    input  logic [71:0] s_axis_tdata,
    input  logic [1:0]  s_axis_tuser,   // operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // seconds_out[31:0], year_out[39:32], month_out[43:40], day_out[48:44],
    // hour_out[53:49], minute_out[59:54], second_out[65:60], zero fill
    output logic [71:0] m_axis_tdata,
    output logic        m_axis_tuser    // range_error
);
    import ecc_pkg::*;

    ecc_in_t  in_data;
    ecc_st2_t st2;
    ecc_st4_t st4;
    ecc_out_t res;
    logic     v2, r2, v4, r4;

    always_comb
    begin
        in_data.op      = ecc_op_t'(s_axis_tuser);
        in_data.seconds = s_axis_tdata[31:0];
        in_data.year    = s_axis_tdata[38:32];
        in_data.month   = s_axis_tdata[42:39];
        in_data.day     = s_axis_tdata[47:43];
        in_data.hour    = s_axis_tdata[52:48];
        in_data.minute  = s_axis_tdata[58:53];
        in_data.second  = s_axis_tdata[64:59];
    end

    ecc_day_split u_day_split (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_data   (in_data),
        .out_valid (v2),
        .out_ready (r2),
        .out_data  (st2)
    );

    ecc_time_split u_time_split (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v2),
        .in_ready  (r2),
        .in_data   (st2),
        .out_valid (v4),
        .out_ready (r4),
        .out_data  (st4)
    );

    ecc_field_out u_field_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v4),
        .in_ready  (r4),
        .in_data   (st4),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (res)
    );

    assign m_axis_tdata = {6'd0, res.second, res.minute, res.hour, res.day,
                           res.month, res.year, res.seconds};
    assign m_axis_tuser = res.range_error;

endmodule

`default_nettype wire

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Streams date and seconds conversions through epoch_calendar_converter and
// checks every result against an in-bench calendar computation, under random
// idling on both sides and one long hold-off at the output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    import ecc_pkg::*;

    localparam int unsigned RANDOM_ITEMS   = 900;
    localparam int unsigned LIMIT_CYCLES   = 200000;
    localparam int unsigned DRAIN_CYCLES   = 20;
    localparam int unsigned HOLD_CYCLES    = 120;
    localparam int unsigned SECS_IN_DAY    = 86400;
    localparam int unsigned DAYS_IN_CYCLE  = 1461;
    localparam int unsigned MAX_PRINTED    = 25;

    // first day of each month in a common year, first day of each year in a cycle
    localparam int unsigned MONTH_START [12] =
        '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
    localparam int unsigned YEAR_START [4] = '{0, 366, 731, 1096};

    typedef struct packed {
        ecc_op_t     op;
        logic [31:0] seconds;
        logic [6:0]  year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } conv_item_t;

    typedef struct packed {
        logic [31:0] seconds;
        logic [7:0]  year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic        range_error;
    } conv_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;
    logic        m_axis_tuser;

    conv_item_t   pending_items [$];
    conv_result_t expected_results [$];
    conv_item_t   offered_item;
    conv_result_t got_result;
    conv_result_t want_result;

    int unsigned total_items    = 0;
    int unsigned accepted_count = 0;
    int unsigned result_count   = 0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;
    int unsigned hold_left      = 0;
    bit          hold_done      = 1'b0;
    int unsigned op_count [4]   = '{0, 0, 0, 0};

    epoch_calendar_converter dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Calendar arithmetic
    // ------------------------------------------------------------------------
    function automatic int unsigned calendar_to_seconds(int unsigned year, int unsigned month,
                                                        int unsigned day, int unsigned hour,
                                                        int unsigned minute,
                                                        int unsigned second);
        int unsigned days;
        days = (year / 4) * DAYS_IN_CYCLE + YEAR_START[year % 4] + MONTH_START[month - 1]
             + (((year % 4) == 0 && month > 2) ? 1 : 0) + day - 1;
        return ((days * 24 + hour) * 60 + minute) * 60 + second;
    endfunction

    function automatic int unsigned month_first_day(int unsigned yr_in_cycle, int unsigned m);
        return MONTH_START[m] + ((yr_in_cycle == 0 && m >= 2) ? 1 : 0);
    endfunction

    function automatic conv_result_t convert(conv_item_t it);
        conv_result_t r;
        int unsigned  rest;
        int unsigned  days;
        int unsigned  rem;
        int unsigned  yr;
        int unsigned  dy;
        int unsigned  mo;
        int           m;
        r = '0;
        case (it.op)
            OP_TO_SECONDS:
            begin
                if (it.year > 99 || it.month < 1 || it.month > 12 || it.day < 1 ||
                    it.hour > 23 || it.minute > 59 || it.second > 59)
                    r.range_error = 1'b1;
                else
                    r.seconds = calendar_to_seconds(it.year, it.month, it.day, it.hour,
                                                    it.minute, it.second);
            end
            OP_TO_CALENDAR:
            begin
                rest     = it.seconds;
                r.second = rest % 60;
                rest     = rest / 60;
                r.minute = rest % 60;
                rest     = rest / 60;
                r.hour   = rest % 24;
                days     = rest / 24;
                rem      = days % DAYS_IN_CYCLE;
                yr       = (rem >= YEAR_START[3]) ? 3 :
                           (rem >= YEAR_START[2]) ? 2 :
                           (rem >= YEAR_START[1]) ? 1 : 0;
                dy       = rem - YEAR_START[yr];
                mo       = 0;
                for (m = 1; m < 12; m++)
                begin
                    if (dy >= month_first_day(yr, m))
                        mo = m;
                end
                r.year  = (days / DAYS_IN_CYCLE) * 4 + yr;
                r.month = mo + 1;
                r.day   = dy - month_first_day(yr, mo) + 1;
            end
            OP_DAY_SECONDS:
                r.seconds = it.seconds % SECS_IN_DAY;
            default:
                r = '0;
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    function automatic void queue_item(ecc_op_t op, logic [31:0] secs, int unsigned year,
                                       int unsigned month, int unsigned day,
                                       int unsigned hour, int unsigned minute,
                                       int unsigned second);
        conv_item_t it;
        it.op      = op;
        it.seconds = secs;
        it.year    = year;
        it.month   = month;
        it.day     = day;
        it.hour    = hour;
        it.minute  = minute;
        it.second  = second;
        pending_items.push_back(it);
    endfunction

    // mostly well-formed dates and calendar-aligned seconds, the rest raw noise
    function automatic conv_item_t random_item();
        conv_item_t  it;
        int unsigned pick;
        it.seconds = $urandom;
        it.year    = $urandom;
        it.month   = $urandom;
        it.day     = $urandom;
        it.hour    = $urandom;
        it.minute  = $urandom;
        it.second  = $urandom;
        pick       = $urandom_range(99);
        if (pick < 40)
        begin
            it.op = OP_TO_SECONDS;
            if ($urandom_range(3) != 0)
            begin
                it.year   = $urandom_range(99);
                it.month  = $urandom_range(12, 1);
                it.day    = ($urandom_range(7) == 0) ? 1 : $urandom_range(31, 1);
                it.hour   = $urandom_range(23);
                it.minute = $urandom_range(59);
                it.second = $urandom_range(59);
            end
        end
        else if (pick < 93)
        begin
            it.op = (pick < 75) ? OP_TO_CALENDAR : OP_DAY_SECONDS;
            // land near a midnight, month or year boundary
            if ($urandom_range(1) != 0)
                it.seconds = calendar_to_seconds($urandom_range(99), $urandom_range(12, 1),
                                                 ($urandom_range(1) != 0) ? 1 :
                                                 $urandom_range(31, 1), 0, 0, 0)
                           + $urandom_range(4) - 2;
        end
        else
            it.op = OP_NONE;
        return it;
    endfunction

    function automatic int unsigned idle_percent(bit receiver);
        if (accepted_count < total_items / 3)
            return receiver ? 85 : 33;
        else if (accepted_count < (total_items * 2) / 3)
            return receiver ? 33 : 85;
        return 0;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED)
            $display("%0t: result %0d %s: expected 0x%0h, got 0x%0h",
                     $time, result_count, what, want, got);
    endtask

    // ------------------------------------------------------------------------
    // Driver
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                expected_results.push_back(convert(offered_item));
                op_count[offered_item.op]++;
                accepted_count++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_items.size() != 0 && $urandom_range(99) >= idle_percent(1'b0))
                begin
                    offered_item  = pending_items.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser  <= offered_item.op;
                    s_axis_tdata  <= {7'd0, offered_item.second, offered_item.minute,
                                      offered_item.hour, offered_item.day,
                                      offered_item.month, offered_item.year,
                                      offered_item.seconds};
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // One long output stall in the no-idle phase; the input keeps offering.
    always @(posedge clk)
    begin
        if (!hold_done && rst_n && accepted_count >= (total_items * 2) / 3 + 40)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // ------------------------------------------------------------------------
    // Monitor
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got_result.seconds     = m_axis_tdata[31:0];
                got_result.year        = m_axis_tdata[39:32];
                got_result.month       = m_axis_tdata[43:40];
                got_result.day         = m_axis_tdata[48:44];
                got_result.hour        = m_axis_tdata[53:49];
                got_result.minute      = m_axis_tdata[59:54];
                got_result.second      = m_axis_tdata[65:60];
                got_result.range_error = m_axis_tuser;
                if (expected_results.size() == 0)
                    report_mismatch("arrived with nothing expected", 0, got_result.seconds);
                else
                begin
                    want_result = expected_results.pop_front();
                    if (got_result.seconds !== want_result.seconds)
                        report_mismatch("seconds_out", want_result.seconds, got_result.seconds);
                    if (got_result.year !== want_result.year)
                        report_mismatch("year_out", want_result.year, got_result.year);
                    if (got_result.month !== want_result.month)
                        report_mismatch("month_out", want_result.month, got_result.month);
                    if (got_result.day !== want_result.day)
                        report_mismatch("day_out", want_result.day, got_result.day);
                    if (got_result.hour !== want_result.hour)
                        report_mismatch("hour_out", want_result.hour, got_result.hour);
                    if (got_result.minute !== want_result.minute)
                        report_mismatch("minute_out", want_result.minute, got_result.minute);
                    if (got_result.second !== want_result.second)
                        report_mismatch("second_out", want_result.second, got_result.second);
                    if (got_result.range_error !== want_result.range_error)
                        report_mismatch("range_error", want_result.range_error,
                                        got_result.range_error);
                end
                result_count++;
            end
            m_axis_tready <= (hold_left == 0) && ($urandom_range(99) >= idle_percent(1'b1));
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_results.size());
            $display("** epoch_calendar_converter: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        // date to seconds: epoch, last valid second, leap day, day past month end
        queue_item(OP_TO_SECONDS, 0, 0, 1, 1, 0, 0, 0);
        queue_item(OP_TO_SECONDS, 0, 99, 12, 31, 23, 59, 59);
        queue_item(OP_TO_SECONDS, 0, 0, 2, 29, 12, 0, 0);
        queue_item(OP_TO_SECONDS, 0, 1, 2, 31, 0, 0, 0);
        queue_item(OP_TO_SECONDS, 0, 3, 12, 31, 23, 59, 59);
        // out-of-range calendar fields
        queue_item(OP_TO_SECONDS, 0, 100, 1, 1, 0, 0, 0);
        queue_item(OP_TO_SECONDS, 0, 5, 0, 1, 0, 0, 0);
        queue_item(OP_TO_SECONDS, 0, 5, 13, 1, 0, 0, 0);
        queue_item(OP_TO_SECONDS, 0, 5, 6, 0, 0, 0, 0);
        queue_item(OP_TO_SECONDS, 0, 5, 6, 15, 24, 0, 0);
        queue_item(OP_TO_SECONDS, 0, 5, 6, 15, 10, 60, 0);
        queue_item(OP_TO_SECONDS, 0, 5, 6, 15, 10, 30, 60);
        queue_item(OP_TO_SECONDS, 32'hFFFF_FFFF, 127, 15, 31, 31, 63, 63);
        // seconds to date across day, leap-day, year and cycle boundaries
        queue_item(OP_TO_CALENDAR, 0, 0, 0, 0, 0, 0, 0);
        queue_item(OP_TO_CALENDAR, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0);
        queue_item(OP_TO_CALENDAR, 86399, 0, 0, 0, 0, 0, 0);
        queue_item(OP_TO_CALENDAR, 59 * SECS_IN_DAY, 0, 0, 0, 0, 0, 0);
        queue_item(OP_TO_CALENDAR, 366 * SECS_IN_DAY - 1, 0, 0, 0, 0, 0, 0);
        queue_item(OP_TO_CALENDAR, 366 * SECS_IN_DAY, 0, 0, 0, 0, 0, 0);
        queue_item(OP_TO_CALENDAR, DAYS_IN_CYCLE * SECS_IN_DAY - 1, 0, 0, 0, 0, 0, 0);
        queue_item(OP_TO_CALENDAR, DAYS_IN_CYCLE * SECS_IN_DAY, 0, 0, 0, 0, 0, 0);
        // time of day
        queue_item(OP_DAY_SECONDS, 86399, 0, 0, 0, 0, 0, 0);
        queue_item(OP_DAY_SECONDS, 86400, 0, 0, 0, 0, 0, 0);
        queue_item(OP_DAY_SECONDS, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0);
        // unused operation code, every field set
        queue_item(OP_NONE, 32'hFFFF_FFFF, 127, 15, 31, 31, 63, 63);
        repeat (RANDOM_ITEMS)
            pending_items.push_back(random_item());
        total_items = pending_items.size();

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_items.size() != 0 || s_axis_tvalid)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d transactions: %0d date-to-seconds, %0d seconds-to-date, %0d time-of-day,",
                 accepted_count, op_count[OP_TO_SECONDS], op_count[OP_TO_CALENDAR],
                 op_count[OP_DAY_SECONDS]);
        $display("%0d unused-op; %0d results checked, %0d mismatches",
                 op_count[OP_NONE], result_count, mismatch_count);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("** epoch_calendar_converter: PASSED **");
        else
            $display("** epoch_calendar_converter: FAILED **");
        $finish;
    end

endmodule
